FILE: design/postfix_expression_evaluator_top_assert.svh
// assertion macros shared by the rtl files
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/pee_pkg.sv
`default_nettype none
package pee_pkg;
   localparam int StackDepth = 16;
   localparam int PtrW = $clog2(StackDepth);
   localparam int CntW = $clog2(StackDepth + 1);
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZERO = 3'd3, ST_BADSYM = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW, OP_BAD
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  digit;
      logic        last;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ_B, S_READ_A, S_EXEC, S_DIV, S_DIV_FIX, S_POW_MUL, S_POW_SQR,
      S_WRITE, S_FIN_READ, S_FIN_WAIT, S_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: design/pee_front.sv
`default_nettype none
module pee_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [7:0]       req_symbol,
   input  wire logic             req_last,
   output logic                  cmd_valid,
   output pee_pkg::cmd_type      cmd_data,
   input  wire logic             cmd_take
);
   import pee_pkg::*;
   `include "postfix_expression_evaluator_top_assert.svh"

   cmd_type             q_ff [QDepth];
   logic [QPtrW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QPtrW:0]      cnt_ff, cnt_in;
   cmd_type             cls;
   logic                do_push, do_pop;

   always_comb begin
      cls.last  = req_last;
      cls.digit = req_symbol[3:0];
      case (req_symbol)
         8'h2B: cls.op = OP_ADD;
         8'h2D: cls.op = OP_SUB;
         8'h2A: cls.op = OP_MUL;
         8'h2F: cls.op = OP_DIV;
         8'h5E: cls.op = OP_POW;
         default: cls.op = (req_symbol inside {[8'h30:8'h39]}) ? OP_PUSH : OP_BAD;
      endcase
   end

   assign req_full  = (cnt_ff == (QPtrW+1)'(QDepth));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= cls;
   end

   `ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= (QPtrW+1)'(QDepth))
   `ASSERT_NEXT(a_cnt_push, clock, reset, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1)
   `ASSERT_NEXT(a_cnt_pop, clock, reset, do_pop && !do_push, cnt_ff == $past(cnt_ff) - 1'b1)
endmodule
`default_nettype wire

FILE: design/pee_back.sv
`default_nettype none
module pee_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire pee_pkg::cmd_type cmd_data,
   output logic                  cmd_take,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic signed [31:0]    rsp_value,
   output logic [2:0]           rsp_status
);
   import pee_pkg::*;
   `include "postfix_expression_evaluator_top_assert.svh"

   logic [31:0]      mem [StackDepth];
   logic [31:0]      rdata_ff;
   logic [PtrW-1:0]  raddr;
   logic             rd_en, wr_en;
   logic [PtrW-1:0]  waddr;
   logic [31:0]      wdata;

   state_type        st_ff, st_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   status_type       err_ff, err_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [31:0]      rem_ff, rem_in;
   logic [5:0]       it_ff, it_in;
   logic             neg_ff, neg_in;
   logic             ov_ff, ov_in;
   logic [31:0]      outv_ff, outv_in;
   status_type       outs_ff, outs_in;
   logic             full_ff, full_in;
   logic [32:0]      trial;
   logic [31:0]      abs_b;
   logic             fin;

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   assign trial = {rem_ff, a_ff[31]} - {1'b0, b_ff};
   assign abs_b = b_ff[31] ? -b_ff : b_ff;
   assign fin   = cmd_ff.last;

   always_comb begin
      st_in = st_ff;
      cmd_take = 1'b0;
      case (st_ff)
         S_IDLE: if (cmd_valid && !full_ff) begin
            cmd_take = 1'b1;
            if (cmd_data.op == OP_PUSH || cnt_ff < CntW'(2)) st_in = S_WRITE;
            else st_in = S_READ_B;
         end
         S_READ_B: st_in = S_READ_A;
         S_READ_A: st_in = S_EXEC;
         S_EXEC: begin
            case (cmd_ff.op)
               OP_DIV: st_in = (b_ff == '0) ? S_WRITE : S_DIV;
               OP_POW: st_in = (b_ff[31] || b_ff == '0) ? S_WRITE : S_POW_MUL;
               default: st_in = S_WRITE;
            endcase
         end
         S_DIV: if (it_ff == 6'd31) st_in = S_DIV_FIX;
         S_DIV_FIX: st_in = S_WRITE;
         S_POW_MUL: st_in = S_POW_SQR;
         S_POW_SQR: if (b_ff[31:1] == '0) st_in = S_WRITE; else st_in = S_POW_MUL;
         S_WRITE: st_in = fin ? S_FIN_READ : S_IDLE;
         S_FIN_READ: st_in = S_FIN_WAIT;
         S_FIN_WAIT: st_in = S_OUT;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff; cnt_in = cnt_ff; err_in = err_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff; rem_in = rem_ff;
      it_in = it_ff; neg_in = neg_ff; ov_in = ov_ff;
      outv_in = outv_ff; outs_in = outs_ff;
      full_in = full_ff && !rsp_pop;
      rd_en = 1'b0; raddr = '0; wr_en = 1'b0; waddr = '0; wdata = r_ff;
      case (st_ff)
         S_IDLE: if (cmd_valid && !full_ff) begin
            cmd_in = cmd_data;
            ov_in = 1'b0;
            r_in = {28'd0, cmd_data.digit - 4'd0};
            if (cmd_data.op != OP_PUSH && cnt_ff >= CntW'(2)) begin
               rd_en = 1'b1; raddr = PtrW'(cnt_ff - CntW'(1));
            end
         end
         S_READ_B: begin
            b_in = rdata_ff;
            rd_en = 1'b1; raddr = PtrW'(cnt_ff - CntW'(2));
         end
         S_EXEC: begin
            a_in = rdata_ff;
            case (cmd_ff.op)
               OP_ADD: r_in = rdata_ff + b_ff;
               OP_SUB: r_in = rdata_ff - b_ff;
               OP_MUL: r_in = rdata_ff * b_ff;
               OP_DIV: begin
                  r_in = '0; rem_in = '0; it_in = '0;
                  neg_in = rdata_ff[31] ^ b_ff[31];
                  a_in = rdata_ff[31] ? -rdata_ff : rdata_ff;
                  b_in = abs_b;
               end
               OP_POW: begin
                  r_in = 32'd1;
                  if (b_ff[31]) begin
                     if (rdata_ff == 32'd1) r_in = 32'd1;
                     else if (rdata_ff == '1) r_in = b_ff[0] ? '1 : 32'd1;
                     else r_in = '0;
                  end
               end
               default: r_in = r_ff;
            endcase
         end
         S_DIV: begin
            a_in = {a_ff[30:0], 1'b0};
            it_in = it_ff + 6'd1;
            if (!trial[32]) begin
               rem_in = trial[31:0]; r_in = {r_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], a_ff[31]}; r_in = {r_ff[30:0], 1'b0};
            end
         end
         S_DIV_FIX: r_in = neg_ff ? -r_ff : r_ff;
         S_POW_MUL: if (b_ff[0]) r_in = r_ff * a_ff;
         S_POW_SQR: begin
            a_in = a_ff * a_ff;
            b_in = {1'b0, b_ff[31:1]};
         end
         S_WRITE: begin
            if (cmd_ff.op == OP_PUSH) begin
               if (cnt_ff >= CntW'(StackDepth)) begin
                  if (err_ff == ST_OK) err_in = ST_OVER;
               end else begin
                  wr_en = 1'b1; waddr = PtrW'(cnt_ff); wdata = r_ff;
                  cnt_in = cnt_ff + CntW'(1);
               end
            end else if (ov_ff == 1'b0 && cnt_ff < CntW'(2)) begin
               if (err_ff == ST_OK) err_in = ST_UNDER;
            end else if (cmd_ff.op == OP_BAD) begin
               cnt_in = cnt_ff - CntW'(2);
               if (err_ff == ST_OK) err_in = ST_BADSYM;
            end else begin
               wr_en = 1'b1; waddr = PtrW'(cnt_ff - CntW'(2)); wdata = r_ff;
               cnt_in = cnt_ff - CntW'(1);
               if (cmd_ff.op == OP_DIV && b_ff == '0 && err_ff == ST_OK) err_in = ST_DIVZERO;
            end
         end
         S_FIN_READ: begin
            rd_en = (cnt_ff != '0); raddr = PtrW'(cnt_ff - CntW'(1));
         end
         S_FIN_WAIT: begin
            outv_in = (cnt_ff == '0) ? '0 : rdata_ff;
            outs_in = (cnt_ff == '0 && err_ff == ST_OK) ? ST_UNDER : err_ff;
         end
         S_OUT: begin
            full_in = 1'b1; cnt_in = '0; err_in = ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; err_ff <= ST_OK; full_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; err_ff <= err_in; full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; r_ff <= r_in; rem_ff <= rem_in;
      it_ff <= it_in; neg_ff <= neg_in; ov_ff <= ov_in; outv_ff <= outv_in;
      outs_ff <= outs_in;
   end

   assign rsp_empty  = !full_ff;
   assign rsp_value  = outv_ff;
   assign rsp_status = outs_ff;

   `ASSERT_IMPL(a_cnt_max, clock, reset, 1'b1, cnt_ff <= CntW'(StackDepth))
   `ASSERT_NEXT(a_out_clear, clock, reset, st_ff == S_OUT, cnt_ff == '0 && err_ff == ST_OK)
   `ASSERT_IMPL(a_take_idle, clock, reset, cmd_take, st_ff == S_IDLE && !full_ff)
endmodule
`default_nettype wire

FILE: design/postfix_expression_evaluator_top.sv
// channel   ports                                    handshake
// req       req_symbol[7:0] req_last                 req_push / req_full
// rsp       rsp_value[31:0] rsp_status[2:0]          rsp_empty / rsp_pop
//
// a transaction queues in a 4-entry command fifo, then runs in the back sequencer
// digit: write only; add/sub/mul: read b, read a, execute, write; divide: one quotient bit a cycle, then a sign fix
// power: a multiply step and a square step per exponent bit up to the highest set bit
// last symbol then reads the top of stack and loads the result register
// synchronous reset clears fifo, sequencer, stack count and error; stack data is kept
// the sequencer stalls while a result waits to be popped
`default_nettype none
module postfix_expression_evaluator_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_symbol,
   input  wire logic          req_last,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);
   import pee_pkg::*;

   logic     cmd_valid, cmd_take;
   cmd_type  cmd_data;

   pee_front u_front (
      .clock, .reset, .req_push, .req_full, .req_symbol, .req_last,
      .cmd_valid, .cmd_data, .cmd_take
   );

   pee_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
      .rsp_empty, .rsp_pop, .rsp_value, .rsp_status
   );
endmodule
`default_nettype wire

FILE: tb/postfix_expression_evaluator_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module postfix_expression_evaluator_top_tb;
   import pee_pkg::*;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } symbol_item_t;

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  status;
   } eval_result_t;

   localparam int WatchdogLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_symbol = 8'd0;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0]  rsp_status;

   symbol_item_t pending_symbols[$];
   eval_result_t expected_results[$];

   logic [31:0] eval_stack[StackDepth];
   int unsigned eval_depth = 0;
   logic [2:0]  eval_error = ST_OK;

   int          mismatches = 0;
   int          send_idle_pct = 20;
   int          recv_idle_pct = 53;
   bit          hold_sender = 1'b0;
   bit          stim_done = 1'b0;
   int          quiet_cycles = 0;
   bit          timed_out = 1'b0;

   postfix_expression_evaluator_top u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_symbol(req_symbol), .req_last(req_last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] power_of(logic [31:0] base, logic [31:0] expo);
      logic [31:0] acc;
      acc = 32'd1;
      if (expo[31]) begin
         if (base == 32'd1) return 32'd1;
         if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (expo != 0) begin
         if (expo[0]) acc = acc * base;
         base = base * base;
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic logic [31:0] quotient_of(logic [31:0] lhs, logic [31:0] rhs);
      longint sl, sr;
      sl = longint'($signed(lhs));
      sr = longint'($signed(rhs));
      return 32'(sl / sr);
   endfunction

   task automatic note_error(logic [2:0] code);
      if (eval_error == ST_OK) eval_error = code;
   endtask

   task automatic evaluate_symbol(symbol_item_t it);
      logic [31:0] lhs, rhs, res;
      eval_result_t r;
      if (it.symbol >= "0" && it.symbol <= "9") begin
         if (eval_depth >= StackDepth) note_error(ST_OVER);
         else begin
            eval_stack[eval_depth] = 32'(it.symbol - "0");
            eval_depth++;
         end
      end else if (eval_depth < 2) begin
         note_error(ST_UNDER);
      end else begin
         rhs = eval_stack[eval_depth-1];
         lhs = eval_stack[eval_depth-2];
         eval_depth -= 2;
         res = 32'd0;
         case (it.symbol)
            "+": res = lhs + rhs;
            "-": res = lhs - rhs;
            "*": res = lhs * rhs;
            "/": begin
               if (rhs == 0) note_error(ST_DIVZERO);
               else res = quotient_of(lhs, rhs);
            end
            "^": res = power_of(lhs, rhs);
            default: note_error(ST_BADSYM);
         endcase
         if (it.symbol inside {"+", "-", "*", "/", "^"}) begin
            eval_stack[eval_depth] = res;
            eval_depth++;
         end
      end
      if (it.last) begin
         r.value = 32'd0;
         if (eval_depth == 0) note_error(ST_UNDER);
         else r.value = eval_stack[eval_depth-1];
         r.status = eval_error;
         expected_results.push_back(r);
         eval_depth = 0;
         eval_error = ST_OK;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            evaluate_symbol('{req_symbol, req_last});
            void'(pending_symbols.pop_front());
         end
         if (pending_symbols.size() > 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_symbol <= pending_symbols[0].symbol;
            req_last <= pending_symbols[0].last;
         end else if (!(req_push && req_full)) begin
            req_push <= 1'b0;
            req_symbol <= 8'($urandom);
            req_last <= 1'($urandom);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      eval_result_t exp_r;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result value=%0d status=%0d", rsp_value, rsp_status);
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.value !== rsp_value || exp_r.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                              $signed(exp_r.value), exp_r.status, rsp_value, rsp_status);
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic queue_expr(string s);
      for (int i = 0; i < s.len(); i++)
         pending_symbols.push_back('{8'(s[i]), 1'(i == s.len() - 1)});
   endtask

   function automatic logic [7:0] pick_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] pick_op();
      case ($urandom_range(4))
         0: return "+";
         1: return "-";
         2: return "*";
         3: return "/";
         default: return "^";
      endcase
   endfunction

   task automatic queue_random_expr();
      int depth, n, kind;
      logic [7:0] s;
      kind = $urandom_range(9);
      n = $urandom_range(1, 12);
      depth = 0;
      for (int i = 0; i < n; i++) begin
         if (kind >= 8) s = 8'($urandom);
         else if (kind == 7 && $urandom_range(3) == 0) s = 8'($urandom);
         else if (depth < 2 || ($urandom_range(1) == 0 && depth < StackDepth + (kind == 6)))
            s = pick_digit();
         else s = pick_op();
         if (s >= "0" && s <= "9") depth++;
         else if (depth >= 2) depth--;
         pending_symbols.push_back('{s, 1'(i == n - 1)});
      end
   endtask

   task automatic wait_drained();
      while (pending_symbols.size() > 0 || expected_results.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      queue_expr("5");
      queue_expr("34+");
      queue_expr("39-");
      queue_expr("99*");
      queue_expr("72/");
      queue_expr("70/");
      queue_expr("23^");
      queue_expr("20^");
      queue_expr("00^");
      queue_expr("104-^");
      queue_expr("901-3-^");
      queue_expr("902-3-^");
      queue_expr("+");
      queue_expr("12!");
      queue_expr("99999999999999999");
      queue_expr("70/1+"); queue_expr("3?");
      queue_expr("12345");
      queue_expr("09-99*99**99**1-*01-/");
      pending_symbols.push_back('{8'hFF, 1'b1});
      pending_symbols.push_back('{8'h00, 1'b1});
      while (pending_symbols.size() < 1450) queue_random_expr();
      hold_sender = 1'b0;
      while (pending_symbols.size() > 950) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_results.size() > 0 || req_push) @(posedge clock);
      hold_sender = 1'b0;
      while (pending_symbols.size() > 500) @(posedge clock);
      send_idle_pct = 53;
      recv_idle_pct = 20;
      while (pending_symbols.size() > 250) @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
